>>> hw/rtl/chbp_pkg.sv
`default_nettype none
package chbp_pkg;

    localparam int CHBP_MAX_BACKENDS = 64;
    localparam int CHBP_RING_DEPTH   = 1024;
    localparam int CHBP_CFG_IDX_W    = 3;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_PICK = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [CHBP_CFG_IDX_W-1:0] CFG_BACKEND_COUNT = 3'd0;
    localparam logic [CHBP_CFG_IDX_W-1:0] CFG_REPLICA_COUNT = 3'd1;
    localparam logic [CHBP_CFG_IDX_W-1:0] CFG_RAMPUP_TICKS  = 3'd2;
    localparam logic [CHBP_CFG_IDX_W-1:0] CFG_ALT_THRESHOLD = 3'd3;

    localparam logic [6:0]  RST_BACKEND_COUNT = 7'd1;
    localparam logic [4:0]  RST_REPLICA_COUNT = 5'd1;
    localparam logic [15:0] RST_RAMPUP_TICKS  = 16'd60;
    // floor(0.10 * 2^31)
    localparam logic [30:0] RST_ALT_THRESHOLD = 31'd214748364;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  entry_index;
        logic [31:0] entry_point;
        logic [5:0]  entry_backend;
        logic [31:0] request_key;
        logic [7:0]  restart_count;
        logic [30:0] random_draw;
        logic [63:0] health_mask;
    } t_req;

    typedef struct packed {
        logic [5:0] chosen_backend;
        logic       found;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_WS_INIT,
        ST_WS_MOD,
        ST_WS_RD,
        ST_WS_CHK,
        ST_WS_RET,
        ST_MH_RD,
        ST_MH_CMP,
        ST_MH_RET,
        ST_HW_BEGIN,
        ST_HW_END,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/consistent_hash_backend_picker.sv
`default_nettype none
// Operation: load and tick requests are taken in the idle state; a pick runs a
// binary search over the ring, then walks ring entries, and checks ramp-up
// state when the chosen backend is marked healthy; every ring read goes
// through the one registered port.
// Throughput: one request at a time; a new request is taken once the previous
// pick has left for the output register. Reset is synchronous and active low;
// it restores the registers, backend health state and tick clock, not the ring.
module consistent_hash_backend_picker #(
    parameter int MAX_BACKENDS = chbp_pkg::CHBP_MAX_BACKENDS,
    parameter int RING_DEPTH   = chbp_pkg::CHBP_RING_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire chbp_pkg::t_req                    i_req,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output chbp_pkg::t_rsp                         o_rsp,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [chbp_pkg::CHBP_CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [30:0]                       i_cfg_data
);
    import chbp_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int NW = $clog2(RING_DEPTH + 1);
    localparam int RW = $clog2(RING_DEPTH + MAX_BACKENDS + 2);
    localparam int PW = RW + 1;

    // ring storage and recovery start times
    logic [31:0] mem_pt  [RING_DEPTH];
    logic [5:0]  mem_own [RING_DEPTH];
    logic [31:0] mem_st  [64];

    t_state r_state, n_state;

    logic [6:0]  r_cfg_nb;
    logic [4:0]  r_cfg_rc;
    logic [15:0] r_rampup;
    logic [30:0] r_thresh;
    logic [31:0] r_tick;
    logic [63:0] r_ready, n_ready;
    logic [63:0] r_armed, n_armed;
    logic [63:0] r_picked, n_picked;
    logic [63:0] r_health;
    logic [31:0] r_key;
    logic [7:0]  r_restarts;
    logic        r_keep;

    logic [6:0]    r_nb, n_nb;
    logic [NW-1:0] r_n, n_n;
    logic [NW-1:0] r_lo, n_lo;
    logic [NW-1:0] r_hi, n_hi;
    logic [NW-1:0] r_mid, n_mid;
    logic [NW-1:0] r_home, n_home;
    logic [RW-1:0] r_ws_r, n_ws_r;
    logic [PW-1:0] r_pos, n_pos;
    logic [5:0]    r_c, n_c;
    logic          r_ws_ok, n_ws_ok;
    logic          r_mh_ok, n_mh_ok;
    logic          r_hw_ok, n_hw_ok;
    logic          r_phase_hw, n_phase_hw;
    logic [8:0]    r_hw_r, n_hw_r;
    logic [8:0]    r_rr, n_rr;
    logic [5:0]    r_be, n_be;
    logic          r_be_ok, n_be_ok;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out, n_out;

    logic [31:0] r_pt_q;
    logic [5:0]  r_own_q;
    logic [31:0] r_st_q;

    logic          accept;
    logic [AW-1:0] rd_addr;
    logic          st_we;
    logic [NW:0]   mid_sum;
    logic [11:0]   prod;
    logic [31:0]   delta;
    logic          mh_is_ready;

    assign accept      = i_valid && !o_stall;
    assign mid_sum     = ({1'b0, r_lo} + {1'b0, r_hi}) >> 1;
    assign prod        = 12'(r_nb) * 12'(r_cfg_rc);
    assign delta       = r_tick - r_st_q;
    assign mh_is_ready = (32'(delta) >= 32'(r_rampup));

    // configuration port
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nb <= RST_BACKEND_COUNT;
            r_cfg_rc <= RST_REPLICA_COUNT;
            r_rampup <= RST_RAMPUP_TICKS;
            r_thresh <= RST_ALT_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BACKEND_COUNT: r_cfg_nb <= i_cfg_data[6:0];
                CFG_REPLICA_COUNT: r_cfg_rc <= i_cfg_data[4:0];
                CFG_RAMPUP_TICKS:  r_rampup <= i_cfg_data[15:0];
                CFG_ALT_THRESHOLD: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ring memory: one write port from load requests, one registered read port
    always_comb begin
        case (r_state)
            ST_SRCH_RD: rd_addr = AW'(mid_sum);
            default:    rd_addr = AW'(r_pos);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.command == CMD_LOAD &&
            32'(i_req.entry_index) < 32'(RING_DEPTH)) begin
            mem_pt[AW'(i_req.entry_index)]  <= i_req.entry_point;
            mem_own[AW'(i_req.entry_index)] <= i_req.entry_backend;
        end
        r_pt_q  <= mem_pt[rd_addr];
        r_own_q <= mem_own[rd_addr];
    end

    // recovery start times; the armed bit marks an entry as valid
    assign st_we = (r_state == ST_MH_RD) && !r_ready[r_c] && !r_armed[r_c];
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            mem_st[r_c] <= r_tick;
        end
        r_st_q <= mem_st[r_c];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_req.command == CMD_PICK) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = (prod == 12'd0) ? ST_FIN : ST_SRCH_RD;
            end
            ST_SRCH_RD: begin
                n_state = (r_lo < r_hi) ? ST_SRCH_CMP : ST_WS_INIT;
            end
            ST_SRCH_CMP: n_state = ST_SRCH_RD;
            ST_WS_INIT: begin
                n_state = (32'(r_ws_r) >= 32'(r_nb)) ? ST_WS_RET : ST_WS_MOD;
            end
            ST_WS_MOD: begin
                if (32'(r_pos) < 32'(r_n)) n_state = ST_WS_RD;
            end
            ST_WS_RD: n_state = ST_WS_CHK;
            ST_WS_CHK: begin
                if (32'(r_ws_r) > 32'(r_n) + 32'(r_nb)) n_state = ST_WS_RET;
                else if (r_picked[r_own_q])          n_state = ST_WS_RD;
                else                                  n_state = ST_WS_RET;
            end
            ST_WS_RET: begin
                if (!r_phase_hw) begin
                    if (r_restarts != 8'd0)  n_state = ST_HW_BEGIN;
                    else if (!r_ws_ok)       n_state = ST_FIN;
                    else if (r_health[r_c])  n_state = ST_MH_RD;
                    else                     n_state = ST_HW_BEGIN;
                end else begin
                    if (!r_ws_ok)            n_state = ST_HW_END;
                    else if (r_health[r_c])  n_state = ST_MH_RD;
                    else                     n_state = ST_HW_BEGIN;
                end
            end
            ST_MH_RD: begin
                n_state = (!r_ready[r_c] && r_armed[r_c]) ? ST_MH_CMP : ST_MH_RET;
            end
            ST_MH_CMP: n_state = ST_MH_RET;
            ST_MH_RET: begin
                if (r_phase_hw)               n_state = ST_HW_END;
                else if (!r_mh_ok || !r_keep) n_state = ST_HW_BEGIN;
                else                          n_state = ST_FIN;
            end
            ST_HW_BEGIN: begin
                n_state = (32'(r_hw_r) >= 32'(r_nb)) ? ST_HW_END : ST_WS_INIT;
            end
            ST_HW_END: begin
                if (r_restarts != 8'd0 && 32'(r_rr) + 32'd1 <= 32'(r_restarts))
                    n_state = ST_HW_BEGIN;
                else
                    n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || !i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_nb        = r_nb;
        n_n         = r_n;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_home      = r_home;
        n_ws_r      = r_ws_r;
        n_pos       = r_pos;
        n_c         = r_c;
        n_ws_ok     = r_ws_ok;
        n_mh_ok     = r_mh_ok;
        n_hw_ok     = r_hw_ok;
        n_phase_hw  = r_phase_hw;
        n_hw_r      = r_hw_r;
        n_rr        = r_rr;
        n_be        = r_be;
        n_be_ok     = r_be_ok;
        n_ready     = r_ready;
        n_armed     = r_armed;
        n_picked    = r_picked;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;

        case (r_state)
            ST_IDLE: begin
                // saturate the backend count
                n_nb = (32'(r_cfg_nb) > 32'(MAX_BACKENDS)) ? 7'(MAX_BACKENDS) : r_cfg_nb;
            end
            ST_SETUP: begin
                n_n        = (32'(prod) > 32'(RING_DEPTH)) ? NW'(RING_DEPTH) : NW'(prod);
                n_lo       = '0;
                n_hi       = (32'(prod) > 32'(RING_DEPTH)) ? NW'(RING_DEPTH) : NW'(prod);
                n_picked   = '0;
                n_be_ok    = 1'b0;
                n_be       = '0;
                n_phase_hw = 1'b0;
            end
            ST_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    n_mid = NW'(mid_sum);
                end else begin
                    n_home = (r_lo >= r_n) ? r_n - NW'(1) : r_lo;
                    n_ws_r = '0;
                end
            end
            ST_SRCH_CMP: begin
                if (r_pt_q < r_key) n_lo = r_mid + NW'(1);
                else                n_hi = r_mid;
            end
            ST_WS_INIT: begin
                if (32'(r_ws_r) >= 32'(r_nb)) n_ws_ok = 1'b0;
                else n_pos = PW'(r_home) + PW'(r_ws_r);
            end
            ST_WS_MOD: begin
                if (32'(r_pos) >= 32'(r_n)) n_pos = r_pos - PW'(r_n);
            end
            ST_WS_RD: begin
                n_ws_r = r_ws_r + RW'(1);
                n_pos  = (32'(r_pos) + 32'd1 == 32'(r_n)) ? '0 : r_pos + PW'(1);
            end
            ST_WS_CHK: begin
                if (32'(r_ws_r) > 32'(r_n) + 32'(r_nb)) begin
                    n_ws_ok = 1'b0;
                end else if (!r_picked[r_own_q]) begin
                    n_picked[r_own_q] = 1'b1;
                    n_c     = r_own_q;
                    n_ws_ok = 1'b1;
                end
            end
            ST_WS_RET: begin
                if (!r_phase_hw) begin
                    n_be    = r_c;
                    n_be_ok = r_ws_ok;
                    if (r_restarts != 8'd0) begin
                        n_rr   = 9'd1;
                        n_hw_r = 9'd1;
                    end else if (r_ws_ok && !r_health[r_c]) begin
                        // drop a ready backend that now reports down
                        if (r_ready[r_c]) begin
                            n_ready[r_c] = 1'b0;
                            n_armed[r_c] = 1'b0;
                        end
                        n_hw_r = '0;
                    end
                end else begin
                    if (!r_ws_ok) begin
                        n_hw_ok = 1'b0;
                    end else if (!r_health[r_c]) begin
                        if (r_ready[r_c]) begin
                            n_ready[r_c] = 1'b0;
                            n_armed[r_c] = 1'b0;
                        end
                        n_hw_r = r_hw_r + 9'd1;
                    end
                end
            end
            ST_MH_RD: begin
                if (r_ready[r_c]) begin
                    n_mh_ok = 1'b1;
                end else if (!r_armed[r_c]) begin
                    // arm now: elapsed time is zero
                    if (r_rampup == 16'd0) begin
                        n_ready[r_c] = 1'b1;
                        n_armed[r_c] = 1'b0;
                        n_mh_ok      = 1'b1;
                    end else begin
                        n_armed[r_c] = 1'b1;
                        n_mh_ok      = 1'b0;
                    end
                end
            end
            ST_MH_CMP: begin
                if (mh_is_ready) begin
                    n_ready[r_c] = 1'b1;
                    n_armed[r_c] = 1'b0;
                    n_mh_ok      = 1'b1;
                end else begin
                    n_mh_ok = 1'b0;
                end
            end
            ST_MH_RET: begin
                if (r_phase_hw) n_hw_ok = 1'b1;
                else            n_hw_r  = '0;
            end
            ST_HW_BEGIN: begin
                if (32'(r_hw_r) >= 32'(r_nb)) begin
                    n_hw_ok = 1'b0;
                end else begin
                    n_ws_r     = RW'(r_hw_r);
                    n_phase_hw = 1'b1;
                end
            end
            ST_HW_END: begin
                if (r_hw_ok) begin
                    n_be    = r_c;
                    n_be_ok = 1'b1;
                end
                n_rr   = r_rr + 9'd1;
                n_hw_r = r_rr + 9'd1;
            end
            ST_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid          = 1'b1;
                    n_out.found          = r_be_ok;
                    n_out.chosen_backend = r_be_ok ? r_be : 6'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ready     <= '1;
            r_armed     <= '0;
            r_picked    <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_armed     <= n_armed;
            r_picked    <= n_picked;
            r_out_valid <= n_out_valid;
            if (accept && i_req.command == CMD_TICK) r_tick <= r_tick + 32'd1;
        end
    end

    // hold request fields and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key      <= i_req.request_key;
            r_restarts <= i_req.restart_count;
            r_keep     <= (i_req.random_draw > r_thresh);
            r_health   <= i_req.health_mask;
        end
        r_nb       <= n_nb;
        r_n        <= n_n;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_home     <= n_home;
        r_ws_r     <= n_ws_r;
        r_pos      <= n_pos;
        r_c        <= n_c;
        r_ws_ok    <= n_ws_ok;
        r_mh_ok    <= n_mh_ok;
        r_hw_ok    <= n_hw_ok;
        r_phase_hw <= n_phase_hw;
        r_hw_r     <= n_hw_r;
        r_rr       <= n_rr;
        r_be       <= n_be;
        r_be_ok    <= n_be_ok;
        r_out      <= n_out;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule
`default_nettype wire

>>> bench/consistent_hash_backend_picker_tb.sv
`default_nettype none
module consistent_hash_backend_picker_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import chbp_pkg::*;

    // command 3 carries nothing; the block drops it
    localparam logic [1:0] CMD_NONE = 2'd3;
    // register index beyond the four defined ones; writes to it are dropped
    localparam logic [CHBP_CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int RING_SLOTS = CHBP_RING_DEPTH;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_req        i_req;
    logic        o_valid;
    logic        i_stall;
    t_rsp        o_rsp;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CHBP_CFG_IDX_W-1:0] i_cfg_index;
    logic [30:0] i_cfg_data;

    consistent_hash_backend_picker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run, big-ring picks included.
    initial begin
        #100ms;
        $display("FAIL consistent_hash_backend_picker");
        $finish;
    end

    // ------------------------------------------------------------------
    // Picker shadow state: ring, per-backend ramp-up, tick clock, registers
    // ------------------------------------------------------------------
    logic [31:0] ring_pt    [0:RING_SLOTS-1];
    logic [5:0]  ring_owner [0:RING_SLOTS-1];
    bit          be_ready   [0:63];
    bit          be_armed   [0:63];
    logic [31:0] be_start   [0:63];
    logic [31:0] tick_now;
    logic [63:0] taken;
    logic [63:0] health_now;

    logic [6:0]  reg_backends;
    logic [4:0]  reg_replicas;
    logic [15:0] reg_rampup;
    logic [30:0] reg_threshold;

    int unsigned live_nb;
    int unsigned live_n;
    int unsigned home_pos;

    t_rsp expected_picks[$];
    int   errors;
    int   picks_seen, found_seen, loads_sent, ticks_sent;

    function automatic int unsigned eff_backends();
        return (reg_backends > CHBP_MAX_BACKENDS) ? CHBP_MAX_BACKENDS : reg_backends;
    endfunction

    function automatic int unsigned eff_ring();
        int unsigned n;
        n = eff_backends() * reg_replicas;
        return (n > RING_SLOTS) ? RING_SLOTS : n;
    endfunction

    // Lower-bound search; a key above every point lands on the last entry.
    function automatic int unsigned ring_search(logic [31:0] key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = live_n;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (ring_pt[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        return (lo >= live_n) ? live_n - 1 : lo;
    endfunction

    // Advance along the ring from offset r to the first backend not yet taken.
    function automatic int next_owner(int unsigned r);
        int unsigned c;
        if (r >= live_nb) return -1;
        forever begin
            c = ring_owner[(home_pos + r) % live_n];
            r++;
            if (r > live_n + live_nb) return -1;
            if (!taken[c]) break;
        end
        taken[c] = 1'b1;
        return int'(c);
    endfunction

    // Returns 1 when the backend is fully up, 0 while still ramping.
    function automatic bit note_up(int c);
        logic [31:0] held;
        if (be_ready[c]) return 1'b1;
        if (!be_armed[c]) begin
            be_armed[c] = 1'b1;
            be_start[c] = tick_now;
        end
        held = tick_now - be_start[c];
        if (held >= {16'd0, reg_rampup}) begin
            be_ready[c] = 1'b1;
            be_armed[c] = 1'b0;
            be_start[c] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void note_down(int c);
        if (be_ready[c]) begin
            be_ready[c] = 1'b0;
            be_armed[c] = 1'b0;
            be_start[c] = '0;
        end
    endfunction

    function automatic int next_healthy(int unsigned r);
        int unsigned steps;
        int c;
        if (r >= live_nb) return -1;
        steps = live_nb - r;
        for (int unsigned i = 0; i < steps; i++) begin
            c = next_owner(r + i);
            if (c < 0) return -1;
            if (health_now[c]) begin
                void'(note_up(c));
                return c;
            end
            note_down(c);
        end
        return -1;
    endfunction

    function automatic t_rsp predict_pick(t_req q);
        t_rsp res;
        bit   keep;
        int   be;
        int   c;
        res = '0;
        keep = q.random_draw > reg_threshold;
        taken = '0;
        health_now = q.health_mask;
        live_nb = eff_backends();
        live_n = eff_ring();
        if (live_nb == 0 || live_n == 0) return res;
        home_pos = ring_search(q.request_key);
        be = next_owner(0);
        if (q.restart_count > 0) begin
            for (int unsigned r = 1; r <= q.restart_count; r++) begin
                c = next_healthy(r);
                if (c >= 0) be = c;
            end
        end else if (be >= 0) begin
            if (health_now[be]) begin
                if (!note_up(be)) keep = 1'b0;
                if (!keep) begin
                    c = next_healthy(0);
                    if (c >= 0) be = c;
                end
            end else begin
                note_down(be);
                c = next_healthy(0);
                if (c >= 0) be = c;
            end
        end
        if (be >= 0) begin
            res.chosen_backend = be[5:0];
            res.found = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: check every accepted result, stall per the current mode
    // ------------------------------------------------------------------
    int unsigned rcv_stall_pct;
    int unsigned hold_cycles;

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_picks.size() == 0) begin
                $error("result with nothing expected: backend %0d found %0d",
                       o_rsp.chosen_backend, o_rsp.found);
                errors++;
            end else begin
                want = expected_picks.pop_front();
                if (o_rsp.chosen_backend !== want.chosen_backend) begin
                    $error("chosen_backend: expected %0d, got %0d",
                           want.chosen_backend, o_rsp.chosen_backend);
                    errors++;
                end
                if (o_rsp.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_rsp.found);
                    errors++;
                end
                picks_seen++;
                if (o_rsp.found === 1'b1) found_seen++;
            end
        end
        // hold off for a long stretch when asked, else stall at random
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    int unsigned send_idle_pct;

    // Offer one request, hold it until taken, then advance the shadow state.
    task automatic send_request(t_req q, bit typed, t_rsp typed_rsp);
        t_rsp r;
        i_valid <= 1'b1;
        i_req   <= q;
        do @(posedge i_clk); while (o_stall);
        case (q.command)
            CMD_LOAD: begin
                ring_pt[q.entry_index]    = q.entry_point;
                ring_owner[q.entry_index] = q.entry_backend;
                loads_sent++;
            end
            CMD_TICK: begin
                tick_now++;
                ticks_sent++;
            end
            CMD_PICK: begin
                r = predict_pick(q);
                expected_picks.push_back(typed ? typed_rsp : r);
            end
            default: ;
        endcase
        // drop valid now and then
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send(t_req q);
        send_request(q, 1'b0, '0);
    endtask

    // Idle the sender until every pick has come back, then let a trailing load
    // or tick finish.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_picks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(int nb, int rc, int ramp, int thr);
        logic [CHBP_CFG_IDX_W-1:0] idx [4];
        logic [30:0] val [4];
        idx[0] = CFG_BACKEND_COUNT; val[0] = 31'(nb);
        idx[1] = CFG_REPLICA_COUNT; val[1] = 31'(rc);
        idx[2] = CFG_RAMPUP_TICKS;  val[2] = 31'(ramp);
        idx[3] = CFG_ALT_THRESHOLD; val[3] = 31'(thr);
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        reg_backends  = val[0][6:0];
        reg_replicas  = val[1][4:0];
        reg_rampup    = val[2][15:0];
        reg_threshold = val[3];
    endtask

    function automatic t_req make_req(logic [1:0] cmd, logic [9:0] idx, logic [31:0] pt,
                                      logic [5:0] be, logic [31:0] key, logic [7:0] rs,
                                      logic [30:0] draw, logic [63:0] hm);
        t_req q;
        q.command = cmd;        q.entry_index = idx;   q.entry_point = pt;
        q.entry_backend = be;   q.request_key = key;   q.restart_count = rs;
        q.random_draw = draw;   q.health_mask = hm;
        return q;
    endfunction

    function automatic t_req random_fields();
        return make_req(2'($urandom), 10'($urandom), $urandom, 6'($urandom), $urandom,
                        8'($urandom), 31'($urandom), {$urandom, $urandom});
    endfunction

    // Load ring positions 0..n-1, ascending points unless asked otherwise.
    task automatic load_ring(int unsigned n, int unsigned nb, bit sorted);
        longint unsigned span;
        t_req q;
        span = 64'h1_0000_0000 / n;
        for (int unsigned i = 0; i < n; i++) begin
            q = random_fields();
            q.command = CMD_LOAD;
            q.entry_index = 10'(i);
            q.entry_point = sorted ? 32'(i * span + $urandom_range(32'(span - 1)))
                                   : $urandom;
            q.entry_backend = ($urandom_range(9) == 0) ? 6'($urandom)
                                                       : 6'($urandom_range(nb - 1));
            send(q);
        end
    endtask

    // One random request shaped for the ring currently loaded.
    function automatic t_req random_item(int unsigned n, int unsigned nb);
        t_req q;
        int unsigned sel;
        q = random_fields();
        sel = $urandom_range(99);
        if (sel < 55) q.command = CMD_PICK;
        else if (sel < 75) q.command = CMD_TICK;
        else if (sel < 93) q.command = CMD_LOAD;
        else q.command = CMD_NONE;
        // keep the ring fully written below n: reload in place
        if (q.command == CMD_LOAD && n > 0 && $urandom_range(1) == 0)
            q.entry_index = 10'($urandom_range(n - 1));
        sel = $urandom_range(9);
        if (n > 0 && sel < 5)
            q.request_key = ring_pt[$urandom_range(n - 1)] + 32'($urandom_range(2)) - 32'd1;
        else if (sel == 5)
            q.request_key = '0;
        else if (sel == 6)
            q.request_key = '1;
        sel = $urandom_range(9);
        if (sel < 4) q.health_mask = '1;
        else if (sel < 7) begin
            q.health_mask = '1;
            repeat ($urandom_range(1, 3))
                q.health_mask[$urandom_range((nb > 0 ? nb : 1) - 1)] = 1'b0;
        end else if (sel == 7) q.health_mask = '0;
        sel = $urandom_range(9);
        if (sel < 6) q.restart_count = '0;
        else if (sel < 9) q.restart_count = 8'($urandom_range(1, 3));
        else if (n > 64) q.restart_count = 8'($urandom_range(4, 8));
        if (sel < 3) q.random_draw = reg_threshold + 31'($urandom_range(2)) - 31'd1;
        return q;
    endfunction

    typedef struct {
        t_req q;
        bit   typed;
        t_rsp want;
    } t_dir_row;

    typedef struct {
        int nb;
        int rc;
        int ramp;
        int thr;
        int mode;
        int items;
        bit sorted;
    } t_phase;

    task automatic set_mode(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; rcv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rcv_stall_pct = 60; end
            default: begin send_idle_pct = 6; rcv_stall_pct = 6; end
        endcase
    endtask

    initial begin
        t_dir_row dir_tab [12];
        t_phase   plan [8];
        t_rsp     top;
        int unsigned n;
        int unsigned nb;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        picks_seen = 0;
        found_seen = 0;
        loads_sent = 0;
        ticks_sent = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        tick_now = '0;
        taken = '0;
        health_now = '0;
        for (int b = 0; b < 64; b++) begin
            be_ready[b] = 1'b1;
            be_armed[b] = 1'b0;
            be_start[b] = '0;
        end
        reg_backends  = RST_BACKEND_COUNT;
        reg_replicas  = RST_REPLICA_COUNT;
        reg_rampup    = RST_RAMPUP_TICKS;
        reg_threshold = RST_ALT_THRESHOLD;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        top.chosen_backend = 6'd63;
        top.found = 1'b1;
        // Reset setting: one backend, one point. Every pick lands on entry 0.
        dir_tab[0]  = '{make_req(CMD_LOAD, 10'd0, 32'h8000_0000, 6'd63, '0, '0, '0, '0),
                        1'b0, '0};
        // top ring slot, loaded but outside the ring in use
        dir_tab[1]  = '{make_req(CMD_LOAD, 10'd1023, '1, 6'd0, '0, '0, '0, '0), 1'b0, '0};
        // unused command: dropped
        dir_tab[2]  = '{make_req(CMD_NONE, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0};
        // lowest key, draw above the threshold, all healthy
        dir_tab[3]  = '{make_req(CMD_PICK, '0, '0, '0, '0, '0, '1, '1), 1'b1, top};
        // key above every point, zero draw forces a diverting walk that finds nothing
        dir_tab[4]  = '{make_req(CMD_PICK, '0, '0, '0, '1, '0, '0, '1), 1'b1, top};
        // everything unhealthy: backend drops out but is still the only answer
        dir_tab[5]  = '{make_req(CMD_PICK, '0, '0, '0, '0, '0, '1, '0), 1'b1, top};
        // back to healthy: ramp-up starts, still chosen
        dir_tab[6]  = '{make_req(CMD_PICK, '0, '0, '0, '0, '0, '1, '1), 1'b1, top};
        dir_tab[7]  = '{make_req(CMD_TICK, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0};
        dir_tab[8]  = '{make_req(CMD_TICK, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0};
        // most restarts: every retry starts beyond the single backend and finds nothing
        dir_tab[9]  = '{make_req(CMD_PICK, '0, '0, '0, 32'h1234_5678, '1, '1, '1), 1'b1, top};
        dir_tab[10] = '{make_req(CMD_LOAD, 10'd0, '0, 6'd0, '0, '0, '0, '0), 1'b0, '0};
        top.chosen_backend = 6'd0;
        dir_tab[11] = '{make_req(CMD_PICK, '0, '0, '0, '0, 8'd1, '0, '0), 1'b1, top};
        foreach (dir_tab[i]) send_request(dir_tab[i].q, dir_tab[i].typed, dir_tab[i].want);
        drain();

        // a write to an unused register index must change nothing
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= '1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        send(make_req(CMD_PICK, '0, '0, '0, '1, '0, '0, '1));
        drain();

        plan[0] = '{8,   4,  0,     0,          0, 50, 1'b1};
        plan[1] = '{0,   3,  5,     1234567,    1, 15, 1'b1};
        plan[2] = '{64,  2,  65535, 2147483647, 1, 40, 1'b1};
        plan[3] = '{127, 1,  1,     0,          2, 30, 1'b1};
        plan[4] = '{5,   1,  3,     1073741824, 3, 60, 1'b1};
        plan[5] = '{2,   0,  7,     5,          0, 10, 1'b1};
        plan[6] = '{16,  2,  10,    858993459,  2, 40, 1'b0};
        plan[7] = '{1,   16, 0,     2147483647, 3, 20, 1'b1};

        foreach (plan[p]) begin
            set_mode(0);
            write_config(plan[p].nb, plan[p].rc, plan[p].ramp, plan[p].thr);
            nb = eff_backends();
            n  = eff_ring();
            if (n > 0) load_ring(n, nb, plan[p].sorted);
            set_mode(plan[p].mode);
            // long receiver hold while requests keep coming: block fills and stalls
            if (p == 0) hold_cycles = 400;
            for (int k = 0; k < plan[p].items; k++) begin
                // sender pause until the pipe is empty
                if (p == 4 && k == plan[p].items / 2) drain();
                send(random_item(n, nb));
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("Covered %0d picks (%0d found), %0d ring loads, %0d ticks over 8 settings",
                 picks_seen, found_seen, loads_sent, ticks_sent);
        $display("including empty rings, saturated sizes and ramp-up diversion.");
        if (errors == 0 && expected_picks.size() == 0) begin
            $display("PASS consistent_hash_backend_picker");
        end else begin
            $display("FAIL consistent_hash_backend_picker");
        end
        $finish;
    end

endmodule
`default_nettype wire
